// File: rtl/bale_pkg.sv
`timescale 1ns / 1ps
package bale_pkg;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF     = 16;
    localparam int DATA_BITS_DEF = 32;

    // Capacity register
    localparam int            CAP_BITS  = 5;
    localparam logic [4:0]    CAP_RESET = 5'd16;

    // Fixed port field widths
    localparam int VALUE_BITS = 32;
    localparam int POS_BITS   = 5;
    localparam int CMD_BITS   = 4;
    localparam int STAT_BITS  = 2;
    localparam int FIDX_BITS  = 4;
    localparam int CNT_BITS   = 5;
    localparam int IN_TDATA_BITS  = 40;
    localparam int OUT_TDATA_BITS = 48;

    // Command codes carried on tuser
    typedef enum logic [CMD_BITS-1:0] {
        CMD_PUSH_FRONT = 4'd0,
        CMD_PUSH_BACK  = 4'd1,
        CMD_INSERT     = 4'd2,
        CMD_POP_FRONT  = 4'd3,
        CMD_POP_BACK   = 4'd4,
        CMD_ERASE      = 4'd5,
        CMD_FRONT      = 4'd6,
        CMD_BACK       = 4'd7,
        CMD_SEARCH     = 4'd8
    } t_cmd;

    // Result status codes
    typedef enum logic [STAT_BITS-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    // Shift action applied to the whole row of cells
    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_INS  = 2'd1,
        OP_DEL  = 2'd2
    } t_cell_op;

    // Control broadcast to every cell
    typedef struct packed {
        t_cell_op op;
        logic     commit;
    } t_cell_ctrl;

    // Sequencer states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

endpackage

// File: rtl/bale_cell.sv
`timescale 1ns / 1ps
module bale_cell #(
    parameter int DATA_BITS = bale_pkg::DATA_BITS_DEF,
    parameter int IW        = 4,
    parameter int CW        = 5,
    parameter int INDEX     = 0
) (
    input  logic                  i_clk,
    input  bale_pkg::t_cell_ctrl  i_ctrl,
    input  logic [IW-1:0]         i_pos,
    input  logic [CW-1:0]         i_cnt,
    input  logic [DATA_BITS-1:0]  i_din,
    input  logic [DATA_BITS-1:0]  i_left,
    input  logic [DATA_BITS-1:0]  i_right,
    output logic [DATA_BITS-1:0]  o_data,
    output logic                  o_match,
    output logic [DATA_BITS-1:0]  o_rd
);

    localparam logic [IW-1:0] IDX  = IW'(INDEX);
    localparam logic [CW-1:0] IDXC = CW'(INDEX);

    logic [DATA_BITS-1:0] r_data;
    logic [DATA_BITS-1:0] n_data;

    // Pick the next entry: take from the left on insert, from the right on erase
    always_comb begin
        n_data = r_data;
        case (i_ctrl.op)
            bale_pkg::OP_INS: begin
                if (IDX > i_pos) begin
                    n_data = i_left;
                end else if (IDX == i_pos) begin
                    n_data = i_din;
                end
            end
            bale_pkg::OP_DEL: begin
                if (IDX >= i_pos) begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    // Hold the entry
    always_ff @(posedge i_clk) begin
        if (i_ctrl.commit) begin
            r_data <= n_data;
        end
    end

    // Compare against the search key; only live entries may hit
    assign o_match = (IDXC < i_cnt) && (r_data == i_din);

    // Drive the read bus only when addressed
    assign o_rd   = (IDX == i_pos) ? r_data : '0;
    assign o_data = r_data;

endmodule

// File: rtl/bounded_array_list_engine.sv
`timescale 1ns / 1ps
// Bounded ordered list of signed values held in a row of cells, one entry per
// cell. Each command word (kind on s_axis_tuser) pushes or pops at either end,
// inserts or erases at a position, reads an end or searches for the first
// equal entry, and returns one result word with the value read, a status, the
// search hit and index, the new count and an empty flag. A command word is
// held, then, once the result register is free, every cell shifts or compares
// in parallel and the result is registered; the result register then waits
// for m_axis_tready, and the next command may be taken while it waits. Entries
// above DEPTH are never held; capacity values above DEPTH act as DEPTH.
module bounded_array_list_engine #(
    parameter int DEPTH     = bale_pkg::DEPTH_DEF,
    parameter int DATA_BITS = bale_pkg::DATA_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [bale_pkg::CAP_BITS-1:0]        i_cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [31:0] value, [36:32] position, [39:37] zero
    input  logic [bale_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
    // [3:0] cmd
    input  logic [bale_pkg::CMD_BITS-1:0]        s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [31:0] data_out, [33:32] status, [34] found, [38:35] found_index,
    // [43:39] count, [44] is_empty, [47:45] zero
    output logic [bale_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > bale_pkg::CAP_BITS) ? CW : bale_pkg::CAP_BITS;
    localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

    // Control state
    bale_pkg::t_state r_state;
    bale_pkg::t_state n_state;
    logic [bale_pkg::CAP_BITS-1:0] r_cap;
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;
    logic                          r_m_valid;

    // Held command
    bale_pkg::t_cmd                r_cmd;
    logic [DATA_BITS-1:0]          r_val;
    logic [bale_pkg::POS_BITS-1:0] r_pos;

    // Decode results
    bale_pkg::t_status  stat;
    bale_pkg::t_cell_ctrl ctrl;
    logic [LW-1:0]      eff_pos;
    logic [LW-1:0]      cnt_ext;
    logic [LW-1:0]      cap_ext;
    logic [LW-1:0]      lim;
    logic [LW-1:0]      pos_ext;
    logic               rd_en;
    logic               srch;
    logic               out_free;
    logic               fire;

    // Row signals
    logic [DATA_BITS-1:0] w_data [DEPTH];
    logic [DATA_BITS-1:0] w_rd   [DEPTH];
    logic [DEPTH-1:0]     w_match;
    logic [DATA_BITS-1:0] rd_all;
    logic                 hit;
    logic [IW-1:0]        hit_idx;

    // Result fields
    logic [bale_pkg::VALUE_BITS-1:0] data_out;
    logic                            found;
    logic [bale_pkg::FIDX_BITS-1:0]  found_idx;
    logic [bale_pkg::CNT_BITS-1:0]   cnt_out;
    logic                            is_empty;

    assign out_free = !r_m_valid || m_axis_tready;

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bale_pkg::S_IDLE: if (s_axis_tvalid) n_state = bale_pkg::S_EXEC;
            bale_pkg::S_EXEC: if (out_free) n_state = bale_pkg::S_IDLE;
            default: n_state = bale_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        fire          = 1'b0;
        unique case (r_state)
            bale_pkg::S_IDLE: s_axis_tready = 1'b1;
            bale_pkg::S_EXEC: fire = out_free;
            default: begin
                s_axis_tready = 1'b0;
                fire          = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bale_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= bale_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // Capture the command word
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd <= bale_pkg::t_cmd'(s_axis_tuser);
            r_val <= DATA_BITS'(signed'(s_axis_tdata[31:0]));
            r_pos <= s_axis_tdata[36:32];
        end
    end

    assign cnt_ext = LW'(r_count);
    assign cap_ext = LW'(r_cap);
    assign lim     = (cap_ext > DEPTH_L) ? DEPTH_L : cap_ext;
    assign pos_ext = LW'(r_pos);

    // Decode the held command against the count and capacity
    always_comb begin
        stat        = bale_pkg::ST_OK;
        ctrl.op     = bale_pkg::OP_HOLD;
        ctrl.commit = fire;
        eff_pos     = '0;
        rd_en       = 1'b0;
        srch        = 1'b0;
        n_count     = r_count;
        unique case (r_cmd) inside
            bale_pkg::CMD_PUSH_FRONT, bale_pkg::CMD_PUSH_BACK, bale_pkg::CMD_INSERT: begin
                if (cnt_ext >= lim) begin
                    stat = bale_pkg::ST_FULL;
                end else begin
                    if (r_cmd == bale_pkg::CMD_PUSH_FRONT) begin
                        eff_pos = '0;
                    end else if (r_cmd == bale_pkg::CMD_PUSH_BACK) begin
                        eff_pos = cnt_ext;
                    end else begin
                        eff_pos = pos_ext;
                    end
                    if (eff_pos > cnt_ext) begin
                        stat = bale_pkg::ST_BADPOS;
                    end else begin
                        ctrl.op = bale_pkg::OP_INS;
                        n_count = CW'(r_count + 1'b1);
                    end
                end
            end
            bale_pkg::CMD_POP_FRONT, bale_pkg::CMD_POP_BACK, bale_pkg::CMD_ERASE: begin
                if (r_count == '0) begin
                    stat = bale_pkg::ST_EMPTY;
                end else begin
                    if (r_cmd == bale_pkg::CMD_POP_FRONT) begin
                        eff_pos = '0;
                    end else if (r_cmd == bale_pkg::CMD_POP_BACK) begin
                        eff_pos = LW'(cnt_ext - 1'b1);
                    end else begin
                        eff_pos = pos_ext;
                    end
                    if (eff_pos >= cnt_ext) begin
                        stat = bale_pkg::ST_BADPOS;
                    end else begin
                        ctrl.op = bale_pkg::OP_DEL;
                        rd_en   = 1'b1;
                        n_count = CW'(r_count - 1'b1);
                    end
                end
            end
            bale_pkg::CMD_FRONT, bale_pkg::CMD_BACK: begin
                if (r_count == '0) begin
                    stat = bale_pkg::ST_EMPTY;
                end else begin
                    eff_pos = (r_cmd == bale_pkg::CMD_FRONT) ? '0 : LW'(cnt_ext - 1'b1);
                    rd_en   = 1'b1;
                end
            end
            bale_pkg::CMD_SEARCH: srch = 1'b1;
            default: stat = bale_pkg::ST_OK;
        endcase
    end

    // Row of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_BITS-1:0] left_d;
        logic [DATA_BITS-1:0] right_d;

        if (g == 0) begin : g_first
            assign left_d = r_val;
        end else begin : g_mid
            assign left_d = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_d = w_data[g];
        end else begin : g_inner
            assign right_d = w_data[g+1];
        end

        bale_cell #(
            .DATA_BITS (DATA_BITS),
            .IW        (IW),
            .CW        (CW),
            .INDEX     (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_pos   (eff_pos[IW-1:0]),
            .i_cnt   (r_count),
            .i_din   (r_val),
            .i_left  (left_d),
            .i_right (right_d),
            .o_data  (w_data[g]),
            .o_match (w_match[g]),
            .o_rd    (w_rd[g])
        );
    end

    // Merge the read bus
    always_comb begin
        rd_all = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_all = rd_all | w_rd[i];
        end
    end

    // Take the lowest matching cell
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_match[i] && !hit) begin
                hit     = 1'b1;
                hit_idx = IW'(i);
            end
        end
    end

    assign data_out  = rd_en ? bale_pkg::VALUE_BITS'(signed'(rd_all)) : '0;
    assign found     = srch && hit;
    assign found_idx = found ? bale_pkg::FIDX_BITS'(hit_idx) : '0;
    assign cnt_out   = bale_pkg::CNT_BITS'(n_count);
    assign is_empty  = (n_count == '0);

    // Advance the count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (fire) begin
            r_count <= n_count;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (fire) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            m_axis_tdata <= {3'b000, is_empty, cnt_out, found_idx, found, stat, data_out};
        end
    end

    assign m_axis_tvalid = r_m_valid;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_take_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == bale_pkg::S_EXEC))
        else $error("taken word did not enter execution");

    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state == bale_pkg::S_EXEC))
        else $error("result appeared without execution");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && ctrl.op == bale_pkg::OP_INS) |=> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("insert did not advance the count");

endmodule
